// File: design/oblr_pkg.sv
package oblr_pkg;

	// Ring geometry. Pointers carry one extra bit so that full and empty differ.
	localparam int DEPTH    = 1024;
	localparam int SLOT_W   = $clog2(DEPTH);
	localparam int PTR_W    = SLOT_W + 1;
	localparam int OCC_W    = 11;
	localparam int MAX_READ = 64;
	localparam int MAXC_W   = 7;

	// Number formatting.
	localparam int NUM_W      = 64;
	localparam int DEC_DIGITS = 20;
	localparam int BCD_W      = 4 * DEC_DIGITS;
	localparam int HEX_DIGITS = NUM_W / 4;
	localparam int CNT_W      = 7;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_X    = 8'h78;
	localparam logic [7:0] ASCII_A    = 8'h61;

	// Stream payload widths.
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 24;

	typedef enum logic [2:0] {
		CMD_PUSH_BYTE = 3'd0,
		CMD_PUSH_DEC  = 3'd1,
		CMD_PUSH_HEX  = 3'd2,
		CMD_POP       = 3'd3,
		CMD_READ      = 3'd4,
		CMD_CLEAR     = 3'd5
	} cmd_code_t;

	typedef enum logic [2:0] {
		SRC_INPUT,
		SRC_DEC,
		SRC_HEX,
		SRC_ZERO,
		SRC_X
	} push_src_t;

	typedef enum logic [1:0] {
		CNT_BITS,
		CNT_DIGITS,
		CNT_HEX,
		CNT_READ
	} cnt_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUSH_BYTE,
		ST_DEC_CONV,
		ST_DEC_TRIM,
		ST_DEC_PUSH,
		ST_HEX_ZERO,
		ST_HEX_X,
		ST_HEX_PUSH,
		ST_POP_RD,
		ST_POP_OUT,
		ST_RD_START,
		ST_RD_ISSUE,
		ST_RD_OUT,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic      latch;
		logic      push;
		push_src_t push_src;
		logic      bcd_step;
		logic      bcd_shift;
		logic      nib_shift;
		logic      cnt_init;
		cnt_sel_t  cnt_sel;
		logic      cnt_dec;
		logic      clear;
		logic      pop_rd;
		logic      rd_init;
		logic      rd_rd;
		logic      out_mem;
		logic      out_none;
		logic      out_last;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_code_t in_cmd;
		logic      out_free;
		logic      occ_zero;
		logic      cnt_last;
		logic      dec_top_zero;
		logic      rd_none;
	} dp_status_t;

endpackage

// File: design/oblr_ctrl.sv
module oblr_ctrl import oblr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					unique case (status.in_cmd)
						CMD_PUSH_BYTE: state_d = ST_PUSH_BYTE;
						CMD_PUSH_DEC: begin
							cmd.cnt_init = 1'b1;
							cmd.cnt_sel  = CNT_BITS;
							state_d      = ST_DEC_CONV;
						end
						CMD_PUSH_HEX: state_d = ST_HEX_ZERO;
						CMD_POP:      state_d = status.occ_zero ? ST_DONE : ST_POP_RD;
						CMD_READ:     state_d = ST_RD_START;
						CMD_CLEAR:    state_d = ST_CLEAR;
						default:      state_d = ST_DONE;
					endcase
				end
			end
			ST_PUSH_BYTE: begin
				cmd.push     = 1'b1;
				cmd.push_src = SRC_INPUT;
				state_d      = ST_DONE;
			end
			ST_DEC_CONV: begin
				cmd.bcd_step = 1'b1;
				cmd.cnt_dec  = 1'b1;
				if (status.cnt_last) begin
					cmd.cnt_init = 1'b1;
					cmd.cnt_sel  = CNT_DIGITS;
					state_d      = ST_DEC_TRIM;
				end
			end
			ST_DEC_TRIM: begin
				// Drop leading zero digits but always keep one.
				if (status.dec_top_zero && !status.cnt_last) begin
					cmd.bcd_shift = 1'b1;
					cmd.cnt_dec   = 1'b1;
				end else begin
					state_d = ST_DEC_PUSH;
				end
			end
			ST_DEC_PUSH: begin
				cmd.push      = 1'b1;
				cmd.push_src  = SRC_DEC;
				cmd.bcd_shift = 1'b1;
				cmd.cnt_dec   = 1'b1;
				if (status.cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_HEX_ZERO: begin
				cmd.push     = 1'b1;
				cmd.push_src = SRC_ZERO;
				state_d      = ST_HEX_X;
			end
			ST_HEX_X: begin
				cmd.push     = 1'b1;
				cmd.push_src = SRC_X;
				cmd.cnt_init = 1'b1;
				cmd.cnt_sel  = CNT_HEX;
				state_d      = ST_HEX_PUSH;
			end
			ST_HEX_PUSH: begin
				cmd.push      = 1'b1;
				cmd.push_src  = SRC_HEX;
				cmd.nib_shift = 1'b1;
				cmd.cnt_dec   = 1'b1;
				if (status.cnt_last) begin
					state_d = ST_DONE;
				end
			end
			ST_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_d    = ST_POP_OUT;
			end
			ST_POP_OUT: begin
				if (status.out_free) begin
					cmd.out_mem  = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_RD_START: begin
				if (status.rd_none) begin
					state_d = ST_DONE;
				end else begin
					cmd.cnt_init = 1'b1;
					cmd.cnt_sel  = CNT_READ;
					cmd.rd_init  = 1'b1;
					state_d      = ST_RD_ISSUE;
				end
			end
			ST_RD_ISSUE: begin
				cmd.rd_rd = 1'b1;
				state_d   = ST_RD_OUT;
			end
			ST_RD_OUT: begin
				if (status.out_free) begin
					cmd.out_mem  = 1'b1;
					cmd.out_last = status.cnt_last;
					cmd.cnt_dec  = 1'b1;
					state_d      = status.cnt_last ? ST_IDLE : ST_RD_ISSUE;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_none = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: design/oblr_dpath.sv
module oblr_dpath import oblr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic [7:0]       mem [DEPTH];
	logic [7:0]       rd_data_q;
	logic [PTR_W-1:0] wp_q, rp_q, rdp_q;
	logic [7:0]       byte_q;
	logic [NUM_W-1:0] num_q;
	logic [MAXC_W-1:0] maxc_q;
	logic [BCD_W-1:0] bcd_q, bcd_adj;
	logic [CNT_W-1:0] cnt_q, cnt_init_val;
	logic             out_valid_q, out_has_q, out_last_q;
	logic [7:0]       out_data_q;
	logic [OCC_W-1:0] out_occ_q;

	logic [PTR_W-1:0]  occ;
	logic [MAXC_W-1:0] maxc_sat, rd_n;
	logic [7:0]        push_byte;
	logic [3:0]        dec_top, hex_top;
	logic [SLOT_W-1:0] rd_addr;
	logic              full, out_free;

	assign occ      = wp_q - rp_q;
	assign full     = (occ == PTR_W'(DEPTH));
	assign maxc_sat = (maxc_q > MAXC_W'(MAX_READ)) ? MAXC_W'(MAX_READ) : maxc_q;
	assign rd_n     = (occ < PTR_W'(maxc_sat)) ? MAXC_W'(occ) : maxc_sat;
	assign dec_top  = bcd_q[BCD_W-1 -: 4];
	assign hex_top  = num_q[NUM_W-1 -: 4];
	assign out_free = !out_valid_q || m_tready;
	assign rd_addr  = cmd.pop_rd ? rp_q[SLOT_W-1:0] : rdp_q[SLOT_W-1:0];

	always_comb begin
		status              = '0;
		status.in_cmd       = cmd_code_t'(s_tdata[2:0]);
		status.out_free     = out_free;
		status.occ_zero     = (occ == '0);
		status.cnt_last     = (cnt_q == CNT_W'(1));
		status.dec_top_zero = (dec_top == 4'd0);
		status.rd_none      = (rd_n == '0);
	end

	always_comb begin
		unique case (cmd.push_src)
			SRC_INPUT: push_byte = byte_q;
			SRC_DEC:   push_byte = ASCII_ZERO + {4'd0, dec_top};
			SRC_HEX:   push_byte = (hex_top < 4'd10) ? ASCII_ZERO + {4'd0, hex_top}
			                                         : ASCII_A + {4'd0, hex_top} - 8'd10;
			SRC_ZERO:  push_byte = ASCII_ZERO;
			SRC_X:     push_byte = ASCII_X;
			default:   push_byte = ASCII_ZERO;
		endcase
	end

	// Shift-and-add-3 binary to BCD: each digit of five or more is corrected first.
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                              : bcd_q[4*i +: 4];
		end
	end

	always_comb begin
		unique case (cmd.cnt_sel)
			CNT_BITS:   cnt_init_val = CNT_W'(NUM_W);
			CNT_DIGITS: cnt_init_val = CNT_W'(DEC_DIGITS);
			CNT_HEX:    cnt_init_val = CNT_W'(HEX_DIGITS);
			CNT_READ:   cnt_init_val = CNT_W'(rd_n);
			default:    cnt_init_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				wp_q <= '0;
				rp_q <= '0;
			end else if (cmd.push) begin
				wp_q <= wp_q + PTR_W'(1);
				if (full) begin
					rp_q <= rp_q + PTR_W'(1);
				end
			end else if (cmd.pop_rd) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			if (cmd.out_mem || cmd.out_none) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wp_q[SLOT_W-1:0]] <= push_byte;
		end
		if (cmd.pop_rd || cmd.rd_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= s_tdata[10:3];
			num_q  <= s_tdata[74:11];
			maxc_q <= s_tdata[81:75];
		end else if (cmd.bcd_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
		end else if (cmd.nib_shift) begin
			num_q <= {num_q[NUM_W-5:0], 4'd0};
		end

		if (cmd.latch) begin
			bcd_q <= '0;
		end else if (cmd.bcd_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], num_q[NUM_W-1]};
		end else if (cmd.bcd_shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end

		if (cmd.cnt_init) begin
			cnt_q <= cnt_init_val;
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end

		if (cmd.rd_init) begin
			rdp_q <= wp_q - PTR_W'(rd_n);
		end else if (cmd.rd_rd) begin
			rdp_q <= rdp_q + PTR_W'(1);
		end

		if (cmd.out_mem || cmd.out_none) begin
			out_data_q <= cmd.out_mem ? rd_data_q : 8'd0;
			out_has_q  <= cmd.out_mem;
			out_last_q <= cmd.out_last;
			out_occ_q  <= OCC_W'(occ);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OCC_W - 8){1'b0}}, out_occ_q, out_data_q};
	assign m_tuser  = out_has_q;
	assign m_tlast  = out_last_q;

endmodule

// File: design/overwriting_byte_log_ring.sv
// Byte log ring of 1024 entries that drops its oldest byte when a push finds it full.
// One request carries a command: push a byte, push a 64-bit number as decimal ASCII
// (most significant digit first, "0" for zero) or as "0x" plus 16 lowercase hex
// digits, pop the oldest byte, read the newest min(occupancy, max_count, 64) bytes
// oldest first without removing them, or clear. Every request returns at least one
// result with the occupancy after the request; a read returns one result per byte,
// tlast marks the final result and tuser says a stored byte is present. Requests are
// handled one at a time by a single-port byte memory: a decimal push first converts the
// number to BCD, then drops leading zero digits and pushes the rest, and a read fetches
// and returns its bytes one at a time. The memory is not cleared after reset; only
// bytes written since the last clear are ever returned.
module overwriting_byte_log_ring import oblr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// command[2:0], byte_value[10:3], number[74:11], max_count[81:75], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// data_byte[7:0], occupancy[18:8], zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// has_data
	output logic                   m_tuser,
	output logic                   m_tlast
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	oblr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	oblr_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// File: design/oblr_checker.sv
module oblr_checker import oblr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	// A waiting result must not change.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// A result without a stored byte has a zero byte and ends its request.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0 && m_tlast)
		else $error("empty result malformed");

	// Occupancy never exceeds the ring depth.
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[18:8] <= 11'(DEPTH))
		else $error("occupancy out of range");

	// A request is never taken in the cycle right after another one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

bind overwriting_byte_log_ring oblr_checker u_oblr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: tb/sv/overwriting_byte_log_ring_tb.sv
module overwriting_byte_log_ring_tb;
	import oblr_pkg::*;

	localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam int DEC_BASE = 10;

	typedef struct {
		logic [7:0]       data;
		logic             has;
		logic [OCC_W-1:0] occ;
		logic             last;
	} ring_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	// Shadow copy of the ring, updated when a request is accepted.
	logic [7:0]       ring_bytes [DEPTH];
	logic [PTR_W-1:0] shadow_wr_ptr = '0;
	logic [PTR_W-1:0] shadow_rd_ptr = '0;
	ring_result_t     pending_results [$];

	int mismatch_count = 0;
	int gap_max = 17;
	int stall_max = 17;
	int hold_off_cycles = 0;

	overwriting_byte_log_ring u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [OCC_W-1:0] shadow_fill();
		return OCC_W'(shadow_wr_ptr - shadow_rd_ptr);
	endfunction

	function automatic void store_byte(logic [7:0] b);
		if (shadow_fill() == OCC_W'(DEPTH))
			shadow_rd_ptr = shadow_rd_ptr + 1'b1;
		ring_bytes[shadow_wr_ptr[SLOT_W-1:0]] = b;
		shadow_wr_ptr = shadow_wr_ptr + 1'b1;
	endfunction

	function automatic void store_decimal(logic [63:0] num);
		logic [7:0] digits [DEC_DIGITS];
		logic [63:0] v;
		int n;
		v = num;
		n = 0;
		if (v == 0) begin
			store_byte(ASCII_ZERO);
			return;
		end
		while (v != 0) begin
			digits[n] = ASCII_ZERO + 8'(v % DEC_BASE);
			v = v / DEC_BASE;
			n++;
		end
		for (int i = n - 1; i >= 0; i--)
			store_byte(digits[i]);
	endfunction

	function automatic void store_hex(logic [63:0] num);
		logic [3:0] d;
		store_byte(ASCII_ZERO);
		store_byte(ASCII_X);
		for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
			d = num[4*i +: 4];
			store_byte(d < DEC_BASE ? ASCII_ZERO + 8'(d) : ASCII_A + 8'(d) - 8'(DEC_BASE));
		end
	endfunction

	function automatic void add_expected(logic [7:0] data, logic has, logic last);
		ring_result_t r;
		r.data = data;
		r.has  = has;
		r.occ  = shadow_fill();
		r.last = last;
		pending_results.push_back(r);
	endfunction

	// Applies one accepted request to the shadow ring and queues its results.
	function automatic void predict_request(logic [2:0] cmd, logic [7:0] b,
			logic [63:0] num, logic [6:0] maxc);
		int n;
		logic [PTR_W-1:0] p;
		logic [7:0] popped;
		case (cmd)
			CMD_PUSH_BYTE: store_byte(b);
			CMD_PUSH_DEC:  store_decimal(num);
			CMD_PUSH_HEX:  store_hex(num);
			CMD_POP: begin
				if (shadow_fill() != 0) begin
					popped = ring_bytes[shadow_rd_ptr[SLOT_W-1:0]];
					shadow_rd_ptr = shadow_rd_ptr + 1'b1;
					add_expected(popped, 1'b1, 1'b1);
					return;
				end
			end
			CMD_READ: begin
				n = (maxc > MAX_READ) ? MAX_READ : int'(maxc);
				if (int'(shadow_fill()) < n)
					n = int'(shadow_fill());
				if (n > 0) begin
					for (int i = 0; i < n; i++) begin
						p = shadow_wr_ptr - PTR_W'(n) + PTR_W'(i);
						add_expected(ring_bytes[p[SLOT_W-1:0]], 1'b1, i == n - 1);
					end
					return;
				end
			end
			CMD_CLEAR: begin
				shadow_wr_ptr = '0;
				shadow_rd_ptr = '0;
			end
			default: ;
		endcase
		add_expected(8'h00, 1'b0, 1'b1);
	endfunction

	function automatic void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin
		ring_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result: expected none, actual data %0d has %0b occ %0d last %0b",
					$time, m_tdata[7:0], m_tuser, m_tdata[18:8], m_tlast);
			end else begin
				want = pending_results.pop_front();
				check_field("data_byte", want.data, m_tdata[7:0]);
				check_field("has_data", want.has, m_tuser);
				check_field("occupancy", want.occ, m_tdata[18:8]);
				check_field("last", want.last, m_tlast);
			end
		end
	end

	// Result side: a random stall before each result, or a long hold-off on request.
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				n = $urandom_range(0, stall_max);
			end
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(logic [2:0] cmd, logic [7:0] b, logic [63:0] num,
			logic [6:0] maxc);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {6'b0, maxc, num, b, cmd};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_request(cmd, b, num, maxc);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		@(negedge clk);
	endtask

	function automatic logic [63:0] random_number();
		if ($urandom_range(0, 9) == 0)
			return 64'd0;
		return {$urandom, $urandom} >> $urandom_range(0, 63);
	endfunction

	task automatic send_random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 22)
			send_request(CMD_PUSH_BYTE, 8'($urandom_range(0, 255)), random_number(), 7'd0);
		else if (r < 40)
			send_request(CMD_PUSH_DEC, 8'($urandom_range(0, 255)), random_number(), 7'd0);
		else if (r < 58)
			send_request(CMD_PUSH_HEX, 8'($urandom_range(0, 255)), random_number(), 7'd0);
		else if (r < 72)
			send_request(CMD_POP, 8'($urandom_range(0, 255)), random_number(), 7'd0);
		else if (r < 97)
			send_request(CMD_READ, 8'd0, random_number(), 7'($urandom_range(0, MAX_READ)));
		else
			send_request(CMD_CLEAR, 8'd0, random_number(), 7'($urandom_range(0, MAX_READ)));
	endtask

	task automatic test_directed();
		send_request(CMD_POP, 8'd0, 64'd0, 7'd0);
		send_request(CMD_READ, 8'd0, 64'd0, 7'd10);
		send_request(CMD_PUSH_BYTE, 8'h00, 64'd0, 7'd0);
		send_request(CMD_PUSH_BYTE, 8'hFF, 64'd0, 7'd0);
		send_request(CMD_PUSH_DEC, 8'd0, 64'd0, 7'd0);
		send_request(CMD_PUSH_DEC, 8'd0, '1, 7'd0);
		send_request(CMD_PUSH_HEX, 8'd0, 64'd0, 7'd0);
		send_request(CMD_PUSH_HEX, 8'd0, '1, 7'd0);
		send_request(CMD_PUSH_HEX, 8'd0, 64'h0123_4567_89ab_cdef, 7'd0);
		send_request(CMD_PUSH_DEC, 8'd0, 64'd1234567890, 7'd0);
		send_request(CMD_READ, 8'd0, 64'd0, 7'd0);
		send_request(CMD_READ, 8'd0, 64'd0, 7'd1);
		send_request(CMD_READ, 8'd0, 64'd0, 7'd64);
		// Counts above the read limit saturate.
		send_request(CMD_READ, 8'd0, 64'd0, 7'd127);
		send_request(CMD_READ, 8'd0, 64'd0, 7'd65);
		send_request(CMD_POP, 8'd0, 64'd0, 7'd0);
		send_request(CMD_POP, 8'd0, 64'd0, 7'd0);
		send_request(CMD_UNUSED_LO, 8'hFF, '1, 7'd127);
		send_request(CMD_UNUSED_HI, 8'h00, 64'd0, 7'd0);
		send_request(CMD_CLEAR, 8'd0, 64'd0, 7'd0);
		send_request(CMD_READ, 8'd0, 64'd0, 7'd5);
		send_request(CMD_POP, 8'd0, 64'd0, 7'd0);
		send_request(CMD_PUSH_BYTE, 8'hA5, 64'd0, 7'd0);
		send_request(CMD_POP, 8'd0, 64'd0, 7'd0);
	endtask

	// Back to back with no stalls: fill past full so the oldest bytes are dropped.
	task automatic test_fill_overwrite();
		gap_max = 0;
		stall_max = 0;
		send_request(CMD_CLEAR, 8'd0, 64'd0, 7'd0);
		repeat (60) send_request(CMD_PUSH_HEX, 8'd0, random_number(), 7'd0);
		send_request(CMD_PUSH_DEC, 8'd0, '1, 7'd0);
		send_request(CMD_READ, 8'd0, 64'd0, 7'd64);
		repeat (3) send_request(CMD_POP, 8'd0, 64'd0, 7'd0);
		repeat (5) send_request(CMD_PUSH_BYTE, 8'($urandom_range(0, 255)), 64'd0, 7'd0);
		send_request(CMD_READ, 8'd0, 64'd0, 7'd64);
		send_request(CMD_READ, 8'd0, 64'd0, 7'($urandom_range(0, MAX_READ)));
	endtask

	task automatic test_random_mix();
		int mode;
		for (int i = 0; i < 260; i++) begin
			if (i % 40 == 0) begin
				mode = $urandom_range(0, 3);
				gap_max = (mode[0]) ? 0 : 17;
				stall_max = (mode[1]) ? 0 : 17;
			end
			send_random_request();
		end
	endtask

	// The result side holds off while requests keep coming, so the input stalls.
	task automatic test_output_hold_off();
		gap_max = 0;
		stall_max = 5;
		hold_off_cycles = 400;
		for (int i = 0; i < 20; i++) begin
			if (i % 2 == 0)
				send_request(CMD_PUSH_HEX, 8'd0, random_number(), 7'd0);
			else
				send_request(CMD_READ, 8'd0, 64'd0, 7'd64);
		end
	endtask

	task automatic test_pause_drain();
		gap_max = 17;
		stall_max = 17;
		repeat (6) begin
			repeat (5) send_random_request();
			wait_drained();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_fill_overwrite();
		test_random_mix();
		test_output_hold_off();
		test_pause_drain();
		wait_drained();
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

endmodule
